FILE: hw/rtl/mpcru_pkg.sv
package mpcru_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OFF_W  = 5;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned REG_W  = 8;

  // register window offsets
  localparam logic [OFF_W-1:0] OFF_CONTROL = 5'd0;
  localparam logic [OFF_W-1:0] OFF_AUX     = 5'd1;
  localparam logic [OFF_W-1:0] OFF_DATA_IN = 5'd4;
  localparam logic [OFF_W-1:0] OFF_REM     = 5'd8;

  localparam int unsigned CLEAR_BIT = 7;

  localparam logic [7:0]        POLY_CRC8   = 8'h07;
  localparam logic [15:0]       POLY_CRC16R = 16'hA001;
  localparam logic [15:0]       POLY_CCITT  = 16'h1021;
  localparam logic [DATA_W-1:0] POLY_CRC32R = 32'hEDB88320;
  localparam logic [DATA_W-1:0] POLY_CRC32C = 32'h82F63B78;

  typedef enum logic [2:0] {
    SEL_NONE   = 3'd0,
    SEL_CRC8   = 3'd1,
    SEL_CRC16R = 3'd2,
    SEL_CCITT  = 3'd3,
    SEL_CRC32R = 3'd4,
    SEL_CRC32C = 3'd5
  } sel_t;

  typedef struct packed {
    logic              req_type;
    logic [OFF_W-1:0]  reg_offset;
    logic [SIZE_W-1:0] access_size;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic  fire;
    item_t item;
  } exec_t;

endpackage

FILE: hw/rtl/mpcru_fold.sv
module mpcru_fold (
  input  mpcru_pkg::sel_t                  sel_i,
  input  logic [mpcru_pkg::DATA_W-1:0]     rem_i,
  input  logic [mpcru_pkg::DATA_W-1:0]     data_i,
  input  logic [2:0]                       nbytes_i,
  output logic [mpcru_pkg::DATA_W-1:0]     rem_o
);
  import mpcru_pkg::*;

  logic [DATA_W-1:0] chain [0:4];

  function automatic logic [DATA_W-1:0] fold_byte(logic [DATA_W-1:0] r, logic [7:0] b,
                                                  sel_t sel);
    logic [DATA_W-1:0] x;
    logic [15:0]       h;
    logic [7:0]        q;
    x = r;
    h = '0;
    q = '0;
    unique case (sel)
      SEL_CRC8: begin
        q = r[7:0] ^ b;
        for (int k = 0; k < 8; k++) begin
          q = q[7] ? ({q[6:0], 1'b0} ^ POLY_CRC8) : {q[6:0], 1'b0};
        end
        x = {24'd0, q};
      end
      SEL_CCITT: begin
        h = r[15:0] ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
          h = h[15] ? ({h[14:0], 1'b0} ^ POLY_CCITT) : {h[14:0], 1'b0};
        end
        x = {16'd0, h};
      end
      SEL_CRC16R: begin
        h = r[15:0] ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
          h = h[0] ? ({1'b0, h[15:1]} ^ POLY_CRC16R) : {1'b0, h[15:1]};
        end
        x = {16'd0, h};
      end
      SEL_CRC32R: begin
        x = r ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
          x = x[0] ? ({1'b0, x[DATA_W-1:1]} ^ POLY_CRC32R) : {1'b0, x[DATA_W-1:1]};
        end
      end
      SEL_CRC32C: begin
        x = r ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
          x = x[0] ? ({1'b0, x[DATA_W-1:1]} ^ POLY_CRC32C) : {1'b0, x[DATA_W-1:1]};
        end
      end
      default: x = r;
    endcase
    return x;
  endfunction

  // four byte folds chained, LSB byte first
  always_comb begin
    chain[0] = rem_i;
    for (int i = 0; i < 4; i++) begin
      chain[i+1] = fold_byte(chain[i], data_i[8*i +: 8], sel_i);
    end
  end

  assign rem_o = chain[nbytes_i];

endmodule

FILE: hw/rtl/mpcru_core.sv
module mpcru_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mpcru_pkg::exec_t                 exec_i,
  output logic [mpcru_pkg::DATA_W-1:0]     result_o
);
  import mpcru_pkg::*;

  logic [REG_W-1:0]  control_r, control_nxt;
  logic [REG_W-1:0]  aux_r, aux_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] folded;
  logic [2:0]        nbytes;
  logic [4:0]        lane_sh;
  logic [DATA_W-1:0] lane_mask;
  logic              is_rem;
  item_t             it;

  assign it      = exec_i.item;
  assign is_rem  = (it.reg_offset[OFF_W-1:2] == OFF_REM[OFF_W-1:2]);
  assign lane_sh = {it.reg_offset[1:0], 3'b000};

  always_comb begin
    if (it.access_size == '0) begin
      nbytes = 3'd1;
    end else if (it.access_size > 4'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = it.access_size[2:0];
    end
  end

  mpcru_fold u_fold (
    .sel_i    (sel_t'(control_r[2:0])),
    .rem_i    (rem_r),
    .data_i   (it.write_data),
    .nbytes_i (nbytes),
    .rem_o    (folded)
  );

  always_comb begin
    control_nxt = control_r;
    aux_nxt     = aux_r;
    rem_nxt     = rem_r;
    result_o    = '0;
    lane_mask   = ((it.access_size == 4'd2) ? 32'h0000FFFF : 32'h000000FF) << lane_sh;
    if (!it.req_type) begin
      if (it.reg_offset == OFF_CONTROL) begin
        result_o = {24'd0, control_r};
      end else if (it.reg_offset == OFF_AUX) begin
        result_o = {24'd0, aux_r};
      end else if (is_rem) begin
        result_o = rem_r >> lane_sh;
      end
    end else if (exec_i.fire) begin
      if (it.reg_offset == OFF_CONTROL) begin
        control_nxt = it.write_data[REG_W-1:0];
        if (it.write_data[CLEAR_BIT]) begin
          rem_nxt = '0;
        end
      end else if (it.reg_offset == OFF_AUX) begin
        aux_nxt = it.write_data[REG_W-1:0];
      end else if (it.reg_offset == OFF_DATA_IN) begin
        rem_nxt = folded;
      end else if (is_rem) begin
        if (it.access_size >= 4'd4) begin
          rem_nxt = it.write_data;
        end else begin
          rem_nxt = (rem_r & ~lane_mask) | ((it.write_data << lane_sh) & lane_mask);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= '0;
      aux_r     <= '0;
      rem_r     <= '0;
    end else begin
      control_r <= control_nxt;
      aux_r     <= aux_nxt;
      rem_r     <= rem_nxt;
    end
  end

endmodule

FILE: hw/rtl/mpcru_outq.sv
module mpcru_outq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push_i,
  input  logic [mpcru_pkg::DATA_W-1:0]     data_i,
  output logic                             space_o,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [mpcru_pkg::DATA_W-1:0]     data_o
);
  import mpcru_pkg::*;

  logic [1:0]        count_r, count_nxt;
  logic [DATA_W-1:0] q0_r, q0_nxt;
  logic [DATA_W-1:0] q1_r, q1_nxt;
  logic              pop;

  assign valid_o = (count_r != 2'd0);
  assign space_o = (count_r != 2'd2);
  assign data_o  = q0_r;
  assign pop     = valid_o && ready_i;

  always_comb begin
    count_nxt = count_r;
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (push_i) begin
      if ((count_r == 2'd0) || (pop && (count_r == 2'd1))) begin
        q0_nxt = data_i;
      end else begin
        q1_nxt = data_i;
      end
    end
    if (push_i && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push_i) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

FILE: hw/rtl/multi_poly_crc_register_unit.sv
// Path: a transfer accepted on in_valid and in_ready is held in the input register, then
// its result enters the result buffer that drives out_valid, stalled while that buffer is full.
// Throughput: one access per cycle while the result buffer has space; the remainder update
// for up to four bytes is done at execute; a two-entry result buffer decouples out_ready.
// Reset (rst_n low, synchronous): control, aux and remainder cleared, pipeline emptied.
module multi_poly_crc_register_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [mpcru_pkg::OFF_W-1:0]      in_reg_offset,
  input  logic [mpcru_pkg::SIZE_W-1:0]     in_access_size,
  input  logic [mpcru_pkg::DATA_W-1:0]     in_write_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpcru_pkg::DATA_W-1:0]     out_read_data
);
  import mpcru_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r, s1_item_nxt;
  logic              space;
  exec_t             exec;
  logic [DATA_W-1:0] result;

  assign exec.fire = s1_valid_r && space;
  assign exec.item = s1_item_r;
  assign in_ready  = !s1_valid_r || exec.fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = '{req_type:    in_req_type,
                       reg_offset:  in_reg_offset,
                       access_size: in_access_size,
                       write_data:  in_write_data};
    end else if (exec.fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  mpcru_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .exec_i   (exec),
    .result_o (result)
  );

  mpcru_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (exec.fire),
    .data_i  (result),
    .space_o (space),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .data_o  (out_read_data)
  );

endmodule

FILE: hw/rtl/mpcru_checker.sv
module mpcru_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_req_type,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mpcru_pkg::DATA_W-1:0]     out_read_data
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result dropped or changed");

  // with no result pending at out_valid, an accepted transfer must surface at out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !out_valid |=> ##1 out_valid)
    else $error("result late on an idle unit");

  // write accesses always return zero
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!in_xfer) && in_xfer && in_req_type && !out_valid
      |=> ##1 (out_valid && (out_read_data == '0)))
    else $error("write access returned non-zero data");

endmodule

bind multi_poly_crc_register_unit mpcru_checker u_mpcru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data)
);

FILE: tb/sv/multi_poly_crc_register_unit_test.sv
module multi_poly_crc_register_unit_test;
  import mpcru_pkg::*;

  localparam int TOTAL_ITEMS  = 1350;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRESSURE_AT  = 300;
  localparam int PRESSURE_LEN = 60;
  localparam int REPORT_CAP   = 100;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // offsets outside the register map
  localparam logic [OFF_W-1:0] OFF_HOLE  = 5'd31;
  localparam logic [OFF_W-1:0] OFF_SPARE = 5'd2;
  // selector code that picks no polynomial
  localparam logic [2:0] SEL_SPARE = 3'd6;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = 1'b0;
  logic [OFF_W-1:0]  in_reg_offset = '0;
  logic [SIZE_W-1:0] in_access_size = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_read_data;

  // travels with the payload: directed rows may carry a typed-in result
  logic              row_fixed = 1'b0;
  logic [DATA_W-1:0] row_fixed_val = '0;

  typedef struct {
    logic              req;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] data;
    bit                fixed;
    logic [DATA_W-1:0] fixed_val;
  } access_row_t;

  access_row_t       directed_rows[$];
  logic [DATA_W-1:0] expected_read_data[$];

  logic [7:0]        ctrl_shadow;
  logic [7:0]        aux_shadow;
  logic [DATA_W-1:0] crc_shadow;

  int  err_count = 0;
  int  sent_count = 0;
  int  accepted_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  multi_poly_crc_register_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_reg_offset  (in_reg_offset),
    .in_access_size (in_access_size),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] fold_reflected(logic [31:0] r, logic [7:0] b,
                                                 logic [31:0] poly);
    r = r ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

  // narrow form keeps 8 bits and feeds the byte in at the bottom
  function automatic logic [15:0] fold_msb(logic [15:0] r, logic [7:0] b,
                                           logic [15:0] poly, bit wide);
    logic set;
    if (wide) begin
      r = r ^ {b, 8'h00};
    end else begin
      r = {8'h00, r[7:0] ^ b};
    end
    for (int i = 0; i < 8; i++) begin
      set = wide ? r[15] : r[7];
      r = r << 1;
      if (!wide) begin
        r[15:8] = 8'h00;
      end
      if (set) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  function automatic void fold_byte(logic [7:0] b);
    logic [31:0] wide_r;
    case (ctrl_shadow[2:0])
      SEL_CRC8: begin
        crc_shadow = {16'h0, fold_msb(crc_shadow[15:0], b, {8'h00, POLY_CRC8}, 1'b0)};
      end
      SEL_CRC16R: begin
        wide_r = fold_reflected({16'h0, crc_shadow[15:0]}, b, {16'h0, POLY_CRC16R});
        crc_shadow = {16'h0, wide_r[15:0]};
      end
      SEL_CCITT: begin
        crc_shadow = {16'h0, fold_msb(crc_shadow[15:0], b, POLY_CCITT, 1'b1)};
      end
      SEL_CRC32R: begin
        crc_shadow = fold_reflected(crc_shadow, b, POLY_CRC32R);
      end
      SEL_CRC32C: begin
        crc_shadow = fold_reflected(crc_shadow, b, POLY_CRC32C);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [31:0] predict_read_data(logic req, logic [OFF_W-1:0] off,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [31:0] data);
    logic [31:0] rd;
    logic [31:0] mask;
    int          sh;
    int          n;
    rd = '0;
    sh = (int'(off) - int'(OFF_REM)) * 8;
    if (req == ACC_READ) begin
      if (off == OFF_CONTROL) begin
        rd = {24'h0, ctrl_shadow};
      end else if (off == OFF_AUX) begin
        rd = {24'h0, aux_shadow};
      end else if (off >= OFF_REM && off < OFF_REM + 5'd4) begin
        rd = crc_shadow >> sh;
      end
    end else begin
      if (off == OFF_CONTROL) begin
        ctrl_shadow = data[7:0];
        if (data[CLEAR_BIT]) begin
          crc_shadow = '0;
        end
      end else if (off == OFF_AUX) begin
        aux_shadow = data[7:0];
      end else if (off == OFF_DATA_IN) begin
        n = (size > 4) ? 4 : ((size == 0) ? 1 : int'(size));
        for (int i = 0; i < n; i++) begin
          fold_byte(data[8*i +: 8]);
        end
      end else if (off >= OFF_REM && off < OFF_REM + 5'd4) begin
        if (size >= 4) begin
          crc_shadow = data;
        end else begin
          mask = ((size == 2) ? 32'h0000FFFF : 32'h000000FF) << sh;
          crc_shadow = (crc_shadow & ~mask) | ((data << sh) & mask);
        end
      end
    end
    return rd;
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && in_valid && in_ready) begin
      want = predict_read_data(in_req_type, in_reg_offset, in_access_size, in_write_data);
      expected_read_data.push_back(row_fixed ? row_fixed_val : want);
      accepted_count <= accepted_count + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_read_data.size() == 0) begin
        if (err_count < REPORT_CAP) begin
          $display("%0t: unexpected transfer, expected none, actual %08h",
                   $time, out_read_data);
        end
        err_count++;
      end else begin
        want = expected_read_data.pop_front();
        if (out_read_data !== want) begin
          if (err_count < REPORT_CAP) begin
            $display("%0t: read_data mismatch, expected %08h, actual %08h",
                     $time, want, out_read_data);
          end
          err_count++;
        end
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  initial begin
    bit pressure_done;
    int stall;
    pressure_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && accepted_count >= PRESSURE_AT) begin
        // long hold-off so the result buffer fills and in_ready drops
        out_ready <= 1'b0;
        repeat (PRESSURE_LEN) @(posedge clk);
        pressure_done = 1'b1;
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                          : $urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------- sender

  function automatic logic [31:0] ctrl_word(bit clr, logic [2:0] sel);
    logic [31:0] w;
    w = {29'h0, sel};
    w[CLEAR_BIT] = clr;
    return w;
  endfunction

  task automatic add_row(logic req, logic [OFF_W-1:0] off, logic [SIZE_W-1:0] size,
                         logic [31:0] data, bit fixed, logic [31:0] fixed_val);
    access_row_t row;
    row.req = req;
    row.off = off;
    row.size = size;
    row.data = data;
    row.fixed = fixed;
    row.fixed_val = fixed_val;
    directed_rows.push_back(row);
  endtask

  task automatic send_access(logic req, logic [OFF_W-1:0] off, logic [SIZE_W-1:0] size,
                             logic [31:0] data, bit fixed, logic [31:0] fixed_val);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_reg_offset  <= off;
    in_access_size <= size;
    in_write_data  <= data;
    row_fixed      <= fixed;
    row_fixed_val  <= fixed_val;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic sender_pause();
    int n;
    n = steady ? 0 : pick_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [2:0]        sel;
    logic [31:0]       word;
    logic [OFF_W-1:0]  lane;
    logic [SIZE_W-1:0] sz;
    logic [OFF_W-1:0]  off;

    ctrl_shadow = '0;
    aux_shadow  = '0;
    crc_shadow  = '0;

    // reset values, readback, unmapped offsets
    add_row(ACC_READ,  OFF_CONTROL,     4'd0, 32'h0,        1, 32'h0);
    add_row(ACC_READ,  OFF_REM + 5'd3,  4'd1, 32'hFFFFFFFF, 1, 32'h0);
    add_row(ACC_WRITE, OFF_AUX,         4'd1, 32'hFFFFFFFF, 1, 32'h0);
    add_row(ACC_READ,  OFF_AUX,         4'd0, 32'h0,        1, 32'hFF);
    add_row(ACC_READ,  OFF_HOLE,        4'd8, 32'hFFFFFFFF, 1, 32'h0);
    // whole seed through an upper lane, then a narrow poly drops the high bits
    add_row(ACC_WRITE, OFF_REM + 5'd2,  4'd4, 32'hDEADBEEF, 1, 32'h0);
    add_row(ACC_WRITE, OFF_CONTROL,     4'd1, ctrl_word(0, SEL_CRC8), 1, 32'h0);
    add_row(ACC_WRITE, OFF_DATA_IN,     4'd0, 32'hFFFFFF31, 1, 32'h0);
    add_row(ACC_READ,  OFF_REM,         4'd4, 32'h0,        0, 32'h0);
    // clear in the same transfer as the selector change
    add_row(ACC_WRITE, OFF_CONTROL,     4'd1, ctrl_word(1, SEL_CRC16R), 1, 32'h0);
    add_row(ACC_READ,  OFF_REM,         4'd4, 32'h0,        1, 32'h0);
    add_row(ACC_WRITE, OFF_DATA_IN,     4'd8, 32'h34333231, 1, 32'h0);
    add_row(ACC_READ,  OFF_REM + 5'd1,  4'd2, 32'h0,        0, 32'h0);
    add_row(ACC_WRITE, OFF_CONTROL,     4'd1, ctrl_word(0, SEL_CCITT), 1, 32'h0);
    add_row(ACC_WRITE, OFF_DATA_IN,     4'd3, 32'h00FFFF00, 1, 32'h0);
    add_row(ACC_READ,  OFF_REM,         4'd4, 32'h0,        0, 32'h0);
    add_row(ACC_WRITE, OFF_CONTROL,     4'd1, ctrl_word(1, SEL_CRC32R), 1, 32'h0);
    add_row(ACC_WRITE, OFF_DATA_IN,     4'd4, 32'hFFFFFFFF, 1, 32'h0);
    add_row(ACC_WRITE, OFF_CONTROL,     4'd1, ctrl_word(0, SEL_CRC32C), 1, 32'h0);
    // halfword seed at the top lane loses its upper byte
    add_row(ACC_WRITE, OFF_REM + 5'd3,  4'd2, 32'h0000ABCD, 1, 32'h0);
    add_row(ACC_WRITE, OFF_REM + 5'd1,  4'd1, 32'h0,        1, 32'h0);
    add_row(ACC_READ,  OFF_REM,         4'd0, 32'h0,        0, 32'h0);
    // selector with no polynomial leaves the remainder alone
    add_row(ACC_WRITE, OFF_CONTROL,     4'd1, {24'hFFFFFF, 1'b0, 4'hF, SEL_SPARE}, 1, 32'h0);
    add_row(ACC_WRITE, OFF_DATA_IN,     4'd2, 32'h00001234, 1, 32'h0);
    add_row(ACC_READ,  OFF_REM,         4'd4, 32'h0,        0, 32'h0);
    add_row(ACC_READ,  OFF_CONTROL,     4'd4, 32'h0,        1, {24'h0, 1'b0, 4'hF, SEL_SPARE});
    add_row(ACC_READ,  OFF_DATA_IN,     4'd4, 32'h0,        1, 32'h0);
    add_row(ACC_WRITE, OFF_SPARE,       4'd4, 32'hFFFFFFFF, 1, 32'h0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].req, directed_rows[i].off, directed_rows[i].size,
                  directed_rows[i].data, directed_rows[i].fixed, directed_rows[i].fixed_val);
      sender_pause();
    end

    // mostly well-formed runs: select, optional seed, fold, read lanes back
    while (sent_count < TOTAL_ITEMS) begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      if ($urandom_range(0, 9) < 7) begin
        sel = ($urandom_range(0, 7) != 0) ? 3'($urandom_range(1, 5))
                                          : 3'($urandom_range(0, 7));
        word = $urandom;
        word[2:0] = sel;
        word[CLEAR_BIT] = 1'($urandom_range(0, 1));
        sz = SIZE_W'($urandom_range(0, 8));
        send_access(ACC_WRITE, OFF_CONTROL, sz, word, 0, 32'h0);
        sender_pause();
        if ($urandom_range(0, 1) == 1) begin
          lane = OFF_W'($urandom_range(0, 3));
          sz = SIZE_W'($urandom_range(0, 8));
          send_access(ACC_WRITE, OFF_REM + lane, sz, $urandom, 0, 32'h0);
          sender_pause();
        end
        repeat ($urandom_range(1, 8)) begin
          sz = SIZE_W'($urandom_range(0, 8));
          send_access(ACC_WRITE, OFF_DATA_IN, sz, $urandom, 0, 32'h0);
          sender_pause();
        end
        repeat ($urandom_range(1, 4)) begin
          lane = OFF_W'($urandom_range(0, 3));
          sz = SIZE_W'($urandom_range(0, 8));
          send_access(ACC_READ, OFF_REM + lane, sz, $urandom, 0, 32'h0);
          sender_pause();
        end
      end else begin
        off = OFF_W'($urandom_range(0, 31));
        sz = SIZE_W'($urandom_range(0, 8));
        send_access(1'($urandom_range(0, 1)), off, sz, $urandom, 0, 32'h0);
        sender_pause();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_read_data.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
